// ----- sv/pidc_pkg.sv -----
package pidc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned DT_W   = 31;
    localparam int unsigned INTG_W = 48;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned MOP_W  = 33;
    localparam int unsigned CIDX_W = 3;

    typedef logic [CIDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KP    = 3'd0;
    localparam t_cfg_idx CFG_KI    = 3'd1;
    localparam t_cfg_idx CFG_KD    = 3'd2;
    localparam t_cfg_idx CFG_DT    = 3'd3;
    localparam t_cfg_idx CFG_FLOOR = 3'd4;
    localparam t_cfg_idx CFG_CEIL  = 3'd5;

    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
    localparam logic [DT_W-1:0]          DT_RST   = 31'd65536;

    function automatic logic signed [DATA_W-1:0] f_sat32(input logic signed [PROD_W-1:0] x);
        logic [PROD_W-DATA_W:0] top;
        logic signed [DATA_W-1:0] res;
        top = x[PROD_W-1:DATA_W-1];
        if ((&top) || !(|top)) begin
            res = x[DATA_W-1:0];
        end else if (x[PROD_W-1]) begin
            res = DATA_MIN;
        end else begin
            res = DATA_MAX;
        end
        return res;
    endfunction

endpackage

// ----- sv/pidc_in_if.sv -----
interface pidc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pidc_pkg::DATA_W-1:0]    target;
    logic signed [pidc_pkg::DATA_W-1:0]    measurement;

    modport source (output valid, output target, output measurement, input ready);
    modport sink   (input valid, input target, input measurement, output ready);
endinterface

// ----- sv/pidc_out_if.sv -----
interface pidc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pidc_pkg::DATA_W-1:0]    drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// ----- sv/pidc_mul.sv -----
module pidc_mul (
    input  logic                                  i_clk,
    input  logic signed [pidc_pkg::MOP_W-1:0]     i_a,
    input  logic signed [pidc_pkg::MOP_W-1:0]     i_b,
    output logic signed [pidc_pkg::PROD_W-1:0]    o_prod
);

    logic signed [2*pidc_pkg::MOP_W-1:0] full;
    logic signed [pidc_pkg::PROD_W-1:0]  r_prod;

    assign full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= full[pidc_pkg::PROD_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

// ----- sv/pidc_div.sv -----
module pidc_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [pidc_pkg::PROD_W-1:0]    i_num,
    input  logic [pidc_pkg::DT_W-1:0]             i_den,
    output logic                                  o_done,
    output logic signed [pidc_pkg::DATA_W-1:0]    o_quo
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;

    localparam int unsigned MAG_W = pidc_pkg::PROD_W - 1;
    localparam int unsigned QW    = pidc_pkg::DT_W;

    logic [1:0]                           r_state;
    logic                                 r_neg;
    logic [MAG_W-1:0]                     r_mag;
    logic [pidc_pkg::DATA_W-1:0]          r_rem;
    logic [QW-1:0]                        r_quo;
    logic [4:0]                           r_cnt;
    logic                                 r_done;
    logic signed [pidc_pkg::DATA_W-1:0]   r_res;

    logic [pidc_pkg::PROD_W-1:0]          num_abs;
    logic [pidc_pkg::DATA_W-1:0]          den_x;
    logic [pidc_pkg::DATA_W-1:0]          trial;
    logic                                 qbit;
    logic [pidc_pkg::DATA_W-1:0]          n_rem;
    logic [QW-1:0]                        n_quo;
    logic [pidc_pkg::DATA_W-1:0]          quo_x;

    assign num_abs = i_num[pidc_pkg::PROD_W-1] ? (-i_num) : i_num;
    assign den_x   = {1'b0, i_den};
    assign trial   = {r_rem[pidc_pkg::DATA_W-2:0], r_mag[QW-1]};
    assign qbit    = (trial >= den_x);
    assign n_rem   = qbit ? (trial - den_x) : trial;
    assign n_quo   = {r_quo[QW-2:0], qbit};
    assign quo_x   = {1'b0, n_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_neg   <= i_num[pidc_pkg::PROD_W-1];
                        r_mag   <= num_abs[MAG_W-1:0];
                        r_state <= D_CHK;
                    end
                end
                D_CHK: begin
                    if (r_mag[MAG_W-1:QW] >= den_x) begin
                        r_res   <= r_neg ? pidc_pkg::DATA_MIN : pidc_pkg::DATA_MAX;
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_rem   <= r_mag[MAG_W-1:QW];
                        r_quo   <= '0;
                        r_cnt   <= 5'(QW - 1);
                        r_done  <= 1'b0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_mag  <= r_mag << 1;
                    r_cnt  <= r_cnt - 5'd1;
                    r_done <= (r_cnt == '0);
                    if (r_cnt == '0) begin
                        r_res   <= r_neg ? (-quo_x) : quo_x;
                        r_state <= D_IDLE;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_res;

endmodule

// ----- sv/pid_controller_clamped_core.sv -----
// Accepted words pass S_MINC, S_ACC, S_P, S_IH, S_IL, S_DM, the divider wait
// S_DW (skipped for a zero step, cut short when the quotient saturates), S_SUM.
// Throughput: one word at a time; the next word is taken the cycle after the
// result is registered. The 31-step restoring divider for the derivative sets it.
// Reset (synchronous, active low): gains 0, time step 1.0, floor/ceiling at the
// 32-bit limits, integral and last error cleared, no result pending.
module pid_controller_clamped_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  pidc_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [pidc_pkg::DATA_W-1:0]   i_cfg_data,
    pidc_in_if.sink                       i_in,
    pidc_out_if.source                    o_out
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MINC = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_P    = 4'd3;
    localparam logic [3:0] S_IH   = 4'd4;
    localparam logic [3:0] S_IL   = 4'd5;
    localparam logic [3:0] S_DM   = 4'd6;
    localparam logic [3:0] S_DW   = 4'd7;
    localparam logic [3:0] S_SUM  = 4'd8;

    localparam int unsigned DW = pidc_pkg::DATA_W;
    localparam int unsigned IW = pidc_pkg::INTG_W;
    localparam int unsigned PW = pidc_pkg::PROD_W;
    localparam int unsigned MW = pidc_pkg::MOP_W;
    localparam int unsigned FR = 16;

    logic [3:0]                r_state;
    logic signed [DW-1:0]      r_kp;
    logic signed [DW-1:0]      r_ki;
    logic signed [DW-1:0]      r_kd;
    logic [pidc_pkg::DT_W-1:0] r_dt;
    logic signed [DW-1:0]      r_floor;
    logic signed [DW-1:0]      r_ceil;
    logic signed [IW-1:0]      r_intg;
    logic signed [DW-1:0]      r_last;
    logic signed [DW-1:0]      r_err;
    logic signed [DW-1:0]      r_p;
    logic signed [DW-1:0]      r_i;
    logic signed [DW-1:0]      r_d;
    logic signed [PW-1:0]      r_ihi;
    logic signed [DW-1:0]      r_drive;
    logic                      r_out_valid;

    logic signed [MW-1:0]      mul_a;
    logic signed [MW-1:0]      mul_b;
    logic signed [PW-1:0]      prod;
    logic signed [PW-1:0]      prod_shr;
    logic                      div_start;
    logic                      div_done;
    logic signed [DW-1:0]      div_quo;

    logic signed [DW-1:0]      n_err;
    logic signed [DW-1:0]      diff;
    logic signed [IW:0]        intg_sum;
    logic signed [IW-1:0]      n_intg;
    logic signed [DW+1:0]      pid_sum;
    logic signed [DW-1:0]      pid_sat;
    logic signed [DW-1:0]      n_drive;
    logic                      in_fire;
    logic                      out_fire;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.drive = r_drive;

    assign n_err = pidc_pkg::f_sat32(PW'(i_in.target) - PW'(i_in.measurement));
    assign diff  = pidc_pkg::f_sat32(PW'(r_err) - PW'(r_last));

    assign prod_shr = {{FR{prod[PW-1]}}, prod[PW-1:FR]};

    assign intg_sum = {r_intg[IW-1], r_intg} + {prod[PW-1], prod[IW+FR-1:FR]};
    always_comb begin
        if (intg_sum[IW] != intg_sum[IW-1]) begin
            n_intg = intg_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
            n_intg = intg_sum[IW-1:0];
        end
    end

    assign pid_sum = (DW+2)'(r_p) + (DW+2)'(r_i) + (DW+2)'(r_d);
    assign pid_sat = pidc_pkg::f_sat32(PW'(pid_sum));

    always_comb begin
        priority if (pid_sat > r_ceil) begin
            n_drive = r_ceil;
        end else if (pid_sat < r_floor) begin
            n_drive = r_floor;
        end else begin
            n_drive = pid_sat;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MINC: begin
                mul_a = MW'(r_err);
                mul_b = {2'b00, r_dt};
            end
            S_ACC: begin
                mul_a = MW'(r_kp);
                mul_b = MW'(r_err);
            end
            S_P: begin
                mul_a = MW'(r_ki);
                mul_b = MW'($signed(r_intg[IW-1:FR]));
            end
            S_IH: begin
                mul_a = MW'(r_ki);
                mul_b = {{(MW-FR){1'b0}}, r_intg[FR-1:0]};
            end
            S_IL: begin
                mul_a = MW'(r_kd);
                mul_b = MW'(diff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_start = (r_state == S_DM) && (r_dt != '0);

    pidc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pidc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod),
        .i_den   (r_dt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_dt    <= pidc_pkg::DT_RST;
            r_floor <= pidc_pkg::DATA_MIN;
            r_ceil  <= pidc_pkg::DATA_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pidc_pkg::CFG_KP:    r_kp    <= i_cfg_data;
                pidc_pkg::CFG_KI:    r_ki    <= i_cfg_data;
                pidc_pkg::CFG_KD:    r_kd    <= i_cfg_data;
                pidc_pkg::CFG_DT:    r_dt    <= i_cfg_data[pidc_pkg::DT_W-1:0];
                pidc_pkg::CFG_FLOOR: r_floor <= i_cfg_data;
                pidc_pkg::CFG_CEIL:  r_ceil  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_intg      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_fire && (r_state != S_SUM)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_err   <= n_err;
                        r_state <= S_MINC;
                    end
                end
                S_MINC: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_intg  <= n_intg;
                    r_state <= S_P;
                end
                S_P: begin
                    r_p     <= pidc_pkg::f_sat32(prod_shr);
                    r_state <= S_IH;
                end
                S_IH: begin
                    r_ihi   <= prod;
                    r_state <= S_IL;
                end
                S_IL: begin
                    r_i     <= pidc_pkg::f_sat32(r_ihi + prod_shr);
                    r_state <= S_DM;
                end
                S_DM: begin
                    if (r_dt == '0) begin
                        r_d     <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_DW;
                    end
                end
                S_DW: begin
                    if (div_done) begin
                        r_d     <= div_quo;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_drive     <= n_drive;
                        r_out_valid <= 1'b1;
                        r_last      <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/pidc_drive_checker.sv -----
module pidc_drive_checker
    import pidc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [DATA_W-1:0]   i_cfg_data,
    pidc_in_if                  i_in,
    pidc_out_if                 i_out,
    output int                  o_errors,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [95:0] t_wide;

    localparam int    FRAC_BITS = 16;
    localparam t_wide INTG_HI   = (t_wide'(1) <<< (INTG_W - 1)) - t_wide'(1);
    localparam t_wide INTG_LO   = -(t_wide'(1) <<< (INTG_W - 1));

    logic signed [DATA_W-1:0] kp_gain;
    logic signed [DATA_W-1:0] ki_gain;
    logic signed [DATA_W-1:0] kd_gain;
    logic [DT_W-1:0]          step_dt;
    logic signed [DATA_W-1:0] out_floor;
    logic signed [DATA_W-1:0] out_ceil;

    logic signed [INTG_W-1:0] integ_acc;
    logic signed [DATA_W-1:0] prev_err;

    logic signed [DATA_W-1:0] expected_drive[$];
    int                       fail_count;

    assign o_errors = fail_count;

    function automatic logic signed [DATA_W-1:0] clip32(input t_wide x);
        if (x > t_wide'(DATA_MAX)) return DATA_MAX;
        if (x < t_wide'(DATA_MIN)) return DATA_MIN;
        return x[DATA_W-1:0];
    endfunction

    // advances integral and last error, returns the clamped drive
    function automatic logic signed [DATA_W-1:0] next_drive(
        input logic signed [DATA_W-1:0] tgt,
        input logic signed [DATA_W-1:0] meas
    );
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] diff;
        logic signed [DATA_W-1:0] p_term;
        logic signed [DATA_W-1:0] i_term;
        logic signed [DATA_W-1:0] d_term;
        logic signed [DATA_W-1:0] total;
        t_wide                    acc;
        t_wide                    dt_w;
        dt_w = t_wide'(step_dt);
        err = clip32(t_wide'(tgt) - t_wide'(meas));
        acc = t_wide'(integ_acc) + ((t_wide'(err) * dt_w) >>> FRAC_BITS);
        if (acc > INTG_HI) begin
            acc = INTG_HI;
        end else if (acc < INTG_LO) begin
            acc = INTG_LO;
        end
        integ_acc = acc[INTG_W-1:0];
        p_term = clip32((t_wide'(kp_gain) * t_wide'(err)) >>> FRAC_BITS);
        i_term = clip32((t_wide'(ki_gain) * t_wide'(integ_acc)) >>> FRAC_BITS);
        diff   = clip32(t_wide'(err) - t_wide'(prev_err));
        d_term = '0;
        if (step_dt != '0) begin
            // signed division truncates toward zero
            d_term = clip32((t_wide'(kd_gain) * t_wide'(diff)) / dt_w);
        end
        total = clip32(t_wide'(p_term) + t_wide'(i_term) + t_wide'(d_term));
        if (total > out_ceil) begin
            total = out_ceil;
        end else if (total < out_floor) begin
            total = out_floor;
        end
        prev_err = err;
        return total;
    endfunction

    initial fail_count = 0;

    always @(posedge i_clk) begin : monitor
        logic signed [DATA_W-1:0] want;
        if (!i_rst_n) begin
            kp_gain   = '0;
            ki_gain   = '0;
            kd_gain   = '0;
            step_dt   = DT_RST;
            out_floor = DATA_MIN;
            out_ceil  = DATA_MAX;
            integ_acc = '0;
            prev_err  = '0;
            expected_drive.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KP:    kp_gain   = i_cfg_data;
                    CFG_KI:    ki_gain   = i_cfg_data;
                    CFG_KD:    kd_gain   = i_cfg_data;
                    CFG_DT:    step_dt   = i_cfg_data[DT_W-1:0];
                    CFG_FLOOR: out_floor = i_cfg_data;
                    CFG_CEIL:  out_ceil  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                expected_drive.push_back(next_drive(i_in.target, i_in.measurement));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_drive.size() == 0) begin
                    $display("%0t: drive word %0d with none expected", $time, i_out.drive);
                    fail_count++;
                end else begin
                    want = expected_drive.pop_front();
                    if (i_out.drive !== want) begin
                        $display("%0t: drive mismatch: expected %0d, got %0d",
                                 $time, want, i_out.drive);
                        fail_count++;
                    end
                end
            end
        end
        o_pending <= expected_drive.size();
    end

endmodule

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pidc_pkg::*;

    localparam int RANDOM_ITEMS = 1080;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;

    // indexes past the last register, writes there are dropped
    localparam t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam t_cfg_idx CFG_SPARE_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd65536;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    logic [DATA_W-1:0]   i_cfg_data;

    int                  fail_count;
    int                  pending;
    int                  cycle_cnt;
    bit                  hold_request;
    int                  tx_taken;
    bit                  tx_eager;

    pidc_in_if  in_ch ();
    pidc_out_if out_ch ();

    pid_controller_clamped_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    pidc_drive_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_errors   (fail_count),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic send_word(input logic signed [DATA_W-1:0] tgt,
                             input logic signed [DATA_W-1:0] meas);
        int gap;
        if (tx_taken % 64 == 0) tx_eager = ($urandom_range(0, 2) == 0);
        tx_taken++;
        gap = tx_eager ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.target      <= tgt;
        in_ch.measurement <= meas;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [DATA_W-1:0] kp, ki, kd, dt_word, lo, hi);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        write_reg(CFG_DT, dt_word);
        write_reg(CFG_FLOOR, lo);
        write_reg(CFG_CEIL, hi);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] rand_gain();
        logic [DATA_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3, 4:    return r;
            default: return {{14{r[17]}}, r[17:0]};
        endcase
    endfunction

    // bit 31 is random on purpose, the register keeps only 31 bits
    function automatic logic [DATA_W-1:0] rand_dt();
        logic [DATA_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       r[DT_W-1:0] = '0;
            1:       r[DT_W-1:0] = 31'd1;
            2:       r[DT_W-1:0] = '1;
            3:       ;
            default: r[DT_W-1:0] = 31'($urandom_range(1, 262144));
        endcase
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_extreme();
        case ($urandom_range(0, 5))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    initial begin : result_sink
        int stall;
        int taken;
        bit eager;
        taken = 0;
        eager = 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (taken % 64 == 0) eager = ($urandom_range(0, 2) == 0);
            taken++;
            stall = eager ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: timeout, %0d drive words outstanding", $time, pending);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int                       sent;
        int                       phase;
        int                       n;
        int                       style;
        logic [DATA_W-1:0]        r;
        logic [DATA_W-1:0]        lo;
        logic [DATA_W-1:0]        hi;
        logic signed [DATA_W-1:0] base_t;
        logic signed [DATA_W-1:0] base_m;
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] meas;

        hold_request = 1'b0;
        tx_taken     = 0;
        tx_eager     = 1'b0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_KP;
        i_cfg_data        <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.target      <= '0;
        in_ch.measurement <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains: drive stays zero
        send_word(DATA_MAX, DATA_MIN);
        send_word(DATA_MIN, DATA_MAX);
        wait_drained();

        // extreme gains, smallest step
        apply_config(DATA_MAX, DATA_MIN, DATA_MAX, 32'd1, DATA_MIN, DATA_MAX);
        send_word(DATA_MAX, DATA_MIN);
        send_word(DATA_MIN, DATA_MAX);
        send_word('0, '0);
        send_word(-32'sd1, '0);
        send_word(32'sd1, '0);
        send_word('0, DATA_MIN);
        wait_drained();

        // zero time step through the top bit, plus dropped writes
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h1234_5678);
        apply_config(ONE_Q, ONE_Q, DATA_MIN, 32'h8000_0000, DATA_MIN, DATA_MAX);
        send_word(3 * ONE_Q, '0);
        send_word(DATA_MIN, DATA_MAX);
        send_word(DATA_MAX, DATA_MIN);
        wait_drained();

        // floor above ceiling
        apply_config(ONE_Q, '0, '0, ONE_Q, 10 * ONE_Q, -10 * ONE_Q);
        send_word(20 * ONE_Q, '0);
        send_word('0, '0);
        send_word(-20 * ONE_Q, '0);
        send_word(-5 * ONE_Q, '0);
        wait_drained();

        // largest step: integral runs into its 48-bit limits
        apply_config(DATA_MIN, DATA_MAX, DATA_MIN, 32'h7FFF_FFFF,
                     -1000 * ONE_Q, 1000 * ONE_Q);
        repeat (3) send_word(DATA_MAX, DATA_MIN);
        repeat (2) send_word(DATA_MIN, DATA_MAX);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            r = $urandom;
            case ($urandom_range(0, 4))
                0: begin
                    lo = DATA_MIN;
                    hi = DATA_MAX;
                end
                1: begin
                    lo = $urandom;
                    hi = $urandom;
                end
                default: begin
                    lo = -int'(r[21:0]);
                    hi = int'($urandom_range(0, 4194303));
                end
            endcase
            apply_config(rand_gain(), rand_gain(), rand_gain(), rand_dt(), lo, hi);
            if (phase == 2 || phase == 9) hold_request = 1'b1;
            n      = $urandom_range(20, 120);
            style  = $urandom_range(0, 3);
            base_t = $urandom;
            base_m = $urandom;
            repeat (n) begin
                r = $urandom;
                case (style)
                    0: begin
                        tgt  = $urandom;
                        meas = $urandom;
                    end
                    1: begin
                        tgt  = {{12{r[19]}}, r[19:0]};
                        meas = {{12{r[31]}}, r[31:12]};
                    end
                    2: begin
                        // steady offset winds the integral up
                        tgt  = base_t + {{24{r[7]}}, r[7:0]};
                        meas = base_m;
                    end
                    default: begin
                        tgt  = rand_extreme();
                        meas = rand_extreme();
                    end
                endcase
                send_word(tgt, meas);
            end
            sent += n;
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
